// ===== hdl/upsc_pkg.sv =====
// ----------------------------------------------------------------------------
// upsc_pkg: shared types and constants of the Scale2x/Scale3x upscaler
// Register indexes, reset values and the tag that travels with each block.
// ----------------------------------------------------------------------------
package upsc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 32;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int COORD_W     = 12;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_MODE   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd320;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd240;
    localparam logic                  RST_SCALE_MODE   = 1'b0;

    // one output block to expand: source coordinates and end markers
    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic               last;
        logic               done;
    } blk_tag_t;

    localparam int TAG_W = $bits(blk_tag_t);

endpackage

// ===== hdl/pixel_art_edge_upscaler.sv =====
// ----------------------------------------------------------------------------
// pixel_art_edge_upscaler: streaming Scale2x/Scale3x upscaler
// Source pixels in raster order in, scaled pixels with coordinates out.
// ----------------------------------------------------------------------------
// The front takes one source word per cycle unless held back, reads both
// line stores (one registered read each) and queues one window per output
// block; a source pixel makes up to four blocks. The back emits one pixel
// word per cycle unless the output stalls; a block is 4 words in 2x mode
// and 9 in 3x mode, so an item makes 0 to 36 output words; first-row items
// pass at one per cycle. Output lags input by one row and one column; the
// last row is flushed as it arrives. Mapped config writes restart the frame.
module pixel_art_edge_upscaler
    import upsc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // pixel_in[31:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [55:0]            m_tdata,   // pixel_out[31:0], out_x[43:32], out_y[55:44]
    output logic                   m_tlast,
    output logic                   m_tuser    // frame_done
);

    localparam int QW = TAG_W + 9 * PIXEL_BITS;

    logic                       f_valid, f_ready, b_valid, b_ready, mode;
    logic [8:0][PIXEL_BITS-1:0] f_win, b_win;
    blk_tag_t                   f_tag, b_tag;
    logic [QW-1:0]              b_word;

    upsc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_win     (f_win),
        .q_tag     (f_tag),
        .scale_mode(mode)
    );

    upsc_queue #(
        .DATA_W(QW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(f_valid),
        .wr_ready(f_ready),
        .wr_data ({f_tag, f_win}),
        .rd_valid(b_valid),
        .rd_ready(b_ready),
        .rd_data (b_word)
    );

    assign {b_tag, b_win} = b_word;

    upsc_back #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scale_mode(mode),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_win     (b_win),
        .q_tag     (b_tag),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== hdl/upsc_front.sv =====
// ----------------------------------------------------------------------------
// upsc_front: input side of the upscaler
// Counts raster position, keeps the two line stores and the 3x3 window, and
// queues one window per output block (up to four per source pixel).
// ----------------------------------------------------------------------------
module upsc_front
    import upsc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,
    output logic                        q_valid,
    input  logic                        q_ready,
    output logic [8:0][PIXEL_BITS-1:0]  q_win,
    output blk_tag_t                    q_tag,
    output logic                        scale_mode
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [CFG_DATA_W-1:0] frame_width_reg, frame_height_reg;
    logic                  scale_mode_reg;
    logic [XW-1:0]         col_reg;
    logic [YW-1:0]         row_reg;

    logic [XW:0] weff, xc;
    logic [YW:0] heff, yc;
    logic        acc_lc, acc_lr;

    // stage A: accepted, line store read in flight
    logic                  a_vld_reg;
    logic [PIXEL_BITS-1:0] a_pix_reg;
    logic [XW-1:0]         a_x_reg;
    logic [YW-1:0]         a_y_reg;
    logic                  a_lc_reg, a_lr_reg;
    // stage B: read data back, window update
    logic                  b_vld_reg;
    logic [PIXEL_BITS-1:0] b_pix_reg;
    logic [XW-1:0]         b_x_reg;
    logic [YW-1:0]         b_y_reg;
    logic                  b_lc_reg, b_lr_reg;
    logic                  b_fwd_reg;
    logic [PIXEL_BITS-1:0] b_fwd_old_reg, b_fwd_new_reg;
    logic [PIXEL_BITS-1:0] old_rd_reg, new_rd_reg;
    // stage C: block sequencer
    logic                      c_vld_reg;
    logic [8:0][PIXEL_BITS-1:0] c_win_reg;
    logic [3:0]                c_mask_reg;
    logic [XW-1:0]             c_x_reg;
    logic [YW-1:0]             c_y_reg;
    logic                      c_fd_reg;

    logic [8:0][PIXEL_BITS-1:0] win_reg, win_next;
    logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];

    logic                  acc, a_go, b_go, c_free, push;
    logic [PIXEL_BITS-1:0] old_v, new_v, u_v, m_v, row_v;
    logic [3:0]            b_mask, c_rest;
    logic [1:0]            sel;
    logic [8:0][PIXEL_BITS-1:0] edge_w, sel_w;

    assign cfg_ready  = 1'b1;
    assign scale_mode = scale_mode_reg;

    always_comb begin
        if (frame_width_reg == '0) begin
            weff = (XW+1)'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            weff = (XW+1)'(MAX_WIDTH);
        end else begin
            weff = (XW+1)'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            heff = (YW+1)'(1);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            heff = (YW+1)'(MAX_HEIGHT);
        end else begin
            heff = (YW+1)'(frame_height_reg);
        end
        xc = ({1'b0, col_reg} >= weff) ? weff - 1'b1 : {1'b0, col_reg};
        yc = ({1'b0, row_reg} >= heff) ? heff - 1'b1 : {1'b0, row_reg};
        acc_lc = (xc == weff - 1'b1);
        acc_lr = (yc == heff - 1'b1);
    end

    assign acc      = s_tvalid && s_tready;
    assign b_go     = b_vld_reg && c_free;
    assign a_go     = a_vld_reg && (!b_vld_reg || b_go);
    assign s_tready = !a_vld_reg || a_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            scale_mode_reg   <= RST_SCALE_MODE;
            col_reg          <= '0;
            row_reg          <= '0;
        end else begin
            if (acc) begin
                if (acc_lc) begin
                    col_reg <= '0;
                    row_reg <= acc_lr ? '0 : YW'(yc + 1'b1);
                end else begin
                    col_reg <= XW'(xc + 1'b1);
                    row_reg <= YW'(yc);
                end
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH: begin
                        frame_width_reg <= cfg_data;
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        frame_height_reg <= cfg_data;
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    CFG_SCALE_MODE: begin
                        scale_mode_reg <= cfg_data[0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // stage A
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (s_tready) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            a_pix_reg <= s_tdata[PIXEL_BITS-1:0];
            a_x_reg   <= XW'(xc);
            a_y_reg   <= YW'(yc);
            a_lc_reg  <= acc_lc;
            a_lr_reg  <= acc_lr;
        end
    end

    // line stores: read at stage A, written when stage B retires
    always_ff @(posedge aclk) begin
        if (b_go) begin
            older_mem[b_x_reg] <= new_v;
        end
        if (a_go) begin
            old_rd_reg <= older_mem[a_x_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go) begin
            newer_mem[b_x_reg] <= b_pix_reg;
        end
        if (a_go) begin
            new_rd_reg <= newer_mem[a_x_reg];
        end
    end

    // stage B
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (!b_vld_reg || b_go) begin
            b_vld_reg <= a_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go) begin
            b_pix_reg     <= a_pix_reg;
            b_x_reg       <= a_x_reg;
            b_y_reg       <= a_y_reg;
            b_lc_reg      <= a_lc_reg;
            b_lr_reg      <= a_lr_reg;
            // read raced a write to the same entry: take the written words
            b_fwd_reg     <= b_go && (b_x_reg == a_x_reg);
            b_fwd_old_reg <= new_v;
            b_fwd_new_reg <= b_pix_reg;
        end
    end

    always_comb begin
        old_v = b_fwd_reg ? b_fwd_old_reg : old_rd_reg;
        new_v = b_fwd_reg ? b_fwd_new_reg : new_rd_reg;
        m_v   = (b_y_reg == '0) ? b_pix_reg : new_v;
        u_v   = (b_y_reg <= YW'(1)) ? m_v : old_v;
        win_next = win_reg;
        for (int r = 0; r < 3; r++) begin
            row_v = (r == 0) ? u_v : (r == 1) ? m_v : b_pix_reg;
            if (b_x_reg == '0) begin
                win_next[r*3]   = row_v;
                win_next[r*3+1] = row_v;
            end else begin
                win_next[r*3]   = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
            win_next[r*3+2] = row_v;
        end
        b_mask[0] = (b_y_reg != '0) && (b_x_reg != '0);
        b_mask[1] = (b_y_reg != '0) && b_lc_reg;
        b_mask[2] = b_lr_reg && (b_x_reg != '0);
        b_mask[3] = b_lr_reg && b_lc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (b_go) begin
            win_reg <= win_next;
        end
    end

    // stage C: one block word per cycle into the queue while it has room
    always_comb begin
        if (c_mask_reg[0]) begin
            sel = 2'd0;
        end else if (c_mask_reg[1]) begin
            sel = 2'd1;
        end else if (c_mask_reg[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        c_rest = c_mask_reg & ~(4'b0001 << sel);
        for (int r = 0; r < 3; r++) begin
            edge_w[r*3]   = c_win_reg[r*3+1];
            edge_w[r*3+1] = c_win_reg[r*3+2];
            edge_w[r*3+2] = c_win_reg[r*3+2];
        end
        case (sel)
            2'd0: sel_w = c_win_reg;
            2'd1: sel_w = edge_w;
            2'd2: sel_w = {c_win_reg[8:6], c_win_reg[8:3]};
            default: sel_w = {edge_w[8:6], edge_w[8:3]};
        endcase
        q_win      = sel_w;
        q_tag.sx   = sel[0] ? COORD_W'(c_x_reg) : COORD_W'(c_x_reg) - 1'b1;
        q_tag.sy   = sel[1] ? COORD_W'(c_y_reg) : COORD_W'(c_y_reg) - 1'b1;
        q_tag.last = (c_rest == '0);
        q_tag.done = (c_rest == '0) && c_fd_reg;
    end

    assign q_valid = c_vld_reg;
    assign push    = c_vld_reg && q_ready;
    assign c_free  = !c_vld_reg || (push && c_rest == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg  <= 1'b0;
            c_mask_reg <= '0;
        end else if (b_go) begin
            c_vld_reg  <= |b_mask;
            c_mask_reg <= b_mask;
        end else if (push) begin
            c_vld_reg  <= (c_rest != '0);
            c_mask_reg <= c_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go) begin
            c_win_reg <= win_next;
            c_x_reg   <= b_x_reg;
            c_y_reg   <= b_y_reg;
            c_fd_reg  <= b_lr_reg && b_lc_reg;
        end
    end

endmodule

// ===== hdl/upsc_queue.sv =====
// ----------------------------------------------------------------------------
// upsc_queue: short block queue between front and back
// Register FIFO; lets the front run ahead while the output stalls.
// ----------------------------------------------------------------------------
module upsc_queue
    import upsc_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wp_reg, rp_reg;
    logic [PW:0]       cnt_reg;
    logic              wr, rd;

    assign wr_ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd) begin
                rp_reg <= rp_reg + 1'b1;
            end
            case ({wr, rd})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/upsc_back.sv =====
// ----------------------------------------------------------------------------
// upsc_back: block expander
// Applies the Scale2x/Scale3x rules to one window and walks the 2x2 or 3x3
// block out in raster order through a registered output word.
// ----------------------------------------------------------------------------
module upsc_back
    import upsc_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       scale_mode,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  logic [8:0][PIXEL_BITS-1:0] q_win,
    input  blk_tag_t                   q_tag,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [55:0]                m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    logic                       h_vld_reg;
    logic [8:0][PIXEL_BITS-1:0] h_win_reg;
    blk_tag_t                   h_tag_reg;
    logic [1:0]                 r_reg, k_reg;

    logic                  o_vld_reg, o_last_reg, o_done_reg;
    logic [PIXEL_BITS-1:0] o_pix_reg;
    logic [COORD_W-1:0]    o_x_reg, o_y_reg;

    logic [PIXEL_BITS-1:0] a, b, c, d, e, f, g, h, i, pix;
    logic [PIXEL_BITS-1:0] blk2 [4];
    logic [PIXEL_BITS-1:0] blk3 [9];
    logic                  act, emit, blk_end, k_end;
    logic [1:0]            top;
    logic [3:0]            idx3;
    logic [COORD_W-1:0]    xs, ys;

    always_comb begin
        {i, h, g, f, e, d, c, b, a} = h_win_reg;
        act = (b != h) && (d != f);
        blk2[0] = (act && d == b) ? d : e;
        blk2[1] = (act && b == f) ? f : e;
        blk2[2] = (act && d == h) ? d : e;
        blk2[3] = (act && h == f) ? f : e;
        blk3[0] = blk2[0];
        blk3[1] = (act && ((d == b && e != c) || (b == f && e != a))) ? b : e;
        blk3[2] = blk2[1];
        blk3[3] = (act && ((d == b && e != g) || (d == h && e != a))) ? d : e;
        blk3[4] = e;
        blk3[5] = (act && ((b == f && e != i) || (h == f && e != c))) ? f : e;
        blk3[6] = blk2[2];
        blk3[7] = (act && ((d == h && e != i) || (h == f && e != g))) ? h : e;
        blk3[8] = blk2[3];
        idx3 = (4'(r_reg) << 1) + 4'(r_reg) + 4'(k_reg);
        pix  = scale_mode ? blk3[idx3] : blk2[{r_reg[0], k_reg[0]}];
        top  = scale_mode ? 2'd2 : 2'd1;
        xs   = scale_mode ? (h_tag_reg.sx << 1) + h_tag_reg.sx : h_tag_reg.sx << 1;
        ys   = scale_mode ? (h_tag_reg.sy << 1) + h_tag_reg.sy : h_tag_reg.sy << 1;
    end

    assign emit    = h_vld_reg && (!o_vld_reg || m_tready);
    assign k_end   = (k_reg == top);
    assign blk_end = k_end && (r_reg == top);
    assign q_ready = !h_vld_reg || (emit && blk_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_vld_reg <= 1'b0;
            r_reg     <= '0;
            k_reg     <= '0;
        end else if (q_ready) begin
            h_vld_reg <= q_valid;
            r_reg     <= '0;
            k_reg     <= '0;
        end else if (emit) begin
            k_reg <= k_end ? 2'd0 : k_reg + 1'b1;
            if (k_end) begin
                r_reg <= r_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            h_win_reg <= q_win;
            h_tag_reg <= q_tag;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (emit) begin
            o_vld_reg <= 1'b1;
        end else if (m_tready) begin
            o_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            o_pix_reg  <= pix;
            o_x_reg    <= xs + COORD_W'(k_reg);
            o_y_reg    <= ys + COORD_W'(r_reg);
            o_last_reg <= blk_end && h_tag_reg.last;
            o_done_reg <= blk_end && h_tag_reg.done;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {o_y_reg, o_x_reg, 32'(o_pix_reg)};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_done_reg;

endmodule

// ===== bench/upscale_checker.sv =====
// ----------------------------------------------------------------------------
// upscale_checker: scaled pixel predictor and comparator
// Watches the configuration, source and scaled pixel channels, predicts every
// scaled pixel word from the accepted source words, and compares in order.
// ----------------------------------------------------------------------------
module upscale_checker
    import upsc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [31:0]            s_tdata,   // pixel_in[31:0]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [55:0]            m_tdata,   // pixel_out[31:0], out_x[43:32], out_y[55:44]
    input  logic                   m_tlast,
    input  logic                   m_tuser,   // frame_done
    output int                     mismatches,
    output int                     pending
);

    typedef struct {
        logic [31:0]        pix;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               run_last;
        logic               frame_done;
    } scaled_px_t;

    typedef logic [31:0] window_t [9];

    scaled_px_t scaled_px_q[$];

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic                  mode3x;

    logic [31:0] older_row [DEF_MAX_WIDTH];
    logic [31:0] newer_row [DEF_MAX_WIDTH];
    window_t     nbhd;
    int          col;
    int          row;

    assign pending = scaled_px_q.size();

    // right column duplicated
    function automatic window_t right_clamp(window_t src);
        window_t dst;
        for (int r = 0; r < 3; r++) begin
            dst[r*3+0] = src[r*3+1];
            dst[r*3+1] = src[r*3+2];
            dst[r*3+2] = src[r*3+2];
        end
        return dst;
    endfunction

    // bottom row duplicated
    function automatic window_t bottom_clamp(window_t src);
        window_t dst;
        for (int k = 0; k < 6; k++) dst[k] = src[k+3];
        for (int k = 0; k < 3; k++) dst[k+6] = src[k+6];
        return dst;
    endfunction

    task automatic expand_block(input window_t w, input int sx, input int sy);
        logic [31:0] a, b, c, d, e, f, g, h, i;
        logic [31:0] blk [9];
        logic        act;
        int          s;
        scaled_px_t  px;
        a = w[0]; b = w[1]; c = w[2]; d = w[3]; e = w[4];
        f = w[5]; g = w[6]; h = w[7]; i = w[8];
        s = mode3x ? 3 : 2;
        act = (b != h) && (d != f);
        if (!mode3x) begin
            blk[0] = (act && d == b) ? d : e;
            blk[1] = (act && b == f) ? f : e;
            blk[2] = (act && d == h) ? d : e;
            blk[3] = (act && h == f) ? f : e;
        end else begin
            blk[0] = (act && d == b) ? d : e;
            blk[1] = (act && ((d == b && e != c) || (b == f && e != a))) ? b : e;
            blk[2] = (act && b == f) ? f : e;
            blk[3] = (act && ((d == b && e != g) || (d == h && e != a))) ? d : e;
            blk[4] = e;
            blk[5] = (act && ((b == f && e != i) || (h == f && e != c))) ? f : e;
            blk[6] = (act && d == h) ? d : e;
            blk[7] = (act && ((d == h && e != i) || (h == f && e != g))) ? h : e;
            blk[8] = (act && h == f) ? f : e;
        end
        for (int r = 0; r < s; r++) begin
            for (int k = 0; k < s; k++) begin
                px.pix        = blk[r*s+k];
                px.x          = COORD_W'(sx * s + k);
                px.y          = COORD_W'(sy * s + r);
                px.run_last   = 1'b0;
                px.frame_done = 1'b0;
                scaled_px_q.push_back(px);
            end
        end
    endtask

    task automatic predict_source_pixel(input logic [31:0] p);
        int          wv, hv, x, y, n0;
        logic [31:0] u, m, v;
        logic        last_col, last_row;
        wv = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
        hv = (height_reg == 0) ? 1 : (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
        x = (col >= wv) ? wv - 1 : col;
        y = (row >= hv) ? hv - 1 : row;
        n0 = scaled_px_q.size();
        u = older_row[x];
        m = newer_row[x];
        if (y == 0) m = p;
        if (y <= 1) u = m;
        older_row[x] = newer_row[x];
        newer_row[x] = p;
        for (int r = 0; r < 3; r++) begin
            v = (r == 0) ? u : (r == 1) ? m : p;
            if (x == 0) begin
                nbhd[r*3+0] = v;
                nbhd[r*3+1] = v;
            end else begin
                nbhd[r*3+0] = nbhd[r*3+1];
                nbhd[r*3+1] = nbhd[r*3+2];
            end
            nbhd[r*3+2] = v;
        end
        last_col = (x == wv - 1);
        last_row = (y == hv - 1);
        if (y >= 1) begin
            if (x >= 1) expand_block(nbhd, x - 1, y - 1);
            if (last_col) expand_block(right_clamp(nbhd), x, y - 1);
        end
        if (last_row) begin
            if (x >= 1) expand_block(bottom_clamp(nbhd), x - 1, y);
            if (last_col) expand_block(bottom_clamp(right_clamp(nbhd)), x, y);
        end
        if (scaled_px_q.size() > n0) begin
            scaled_px_q[$].run_last = 1'b1;
            if (last_row && last_col) scaled_px_q[$].frame_done = 1'b1;
        end
        if (last_col) begin
            col = 0;
            row = last_row ? 0 : y + 1;
        end else begin
            col = x + 1;
            row = y;
        end
    endtask

    always @(posedge aclk) begin
        scaled_px_t want;
        if (!aresetn) begin
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            mode3x     = RST_SCALE_MODE;
            col        = 0;
            row        = 0;
            mismatches = 0;
            for (int k = 0; k < 9; k++) nbhd[k] = '0;
            for (int k = 0; k < DEF_MAX_WIDTH; k++) begin
                older_row[k] = '0;
                newer_row[k] = '0;
            end
            scaled_px_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                // unknown indexes leave everything as it is
                if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
                    cfg_index == CFG_SCALE_MODE) begin
                    if (cfg_index == CFG_FRAME_WIDTH)  width_reg  = cfg_data;
                    if (cfg_index == CFG_FRAME_HEIGHT) height_reg = cfg_data;
                    if (cfg_index == CFG_SCALE_MODE)   mode3x     = cfg_data[0];
                    col = 0;
                    row = 0;
                end
            end
            if (s_tvalid && s_tready) predict_source_pixel(s_tdata);
            if (m_tvalid && m_tready) begin
                if (scaled_px_q.size() == 0) begin
                    $error("scaled pixel word with none expected: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = scaled_px_q.pop_front();
                    if (m_tdata[31:0] !== want.pix) begin
                        $error("pixel_out: expected %h, got %h", want.pix, m_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_tdata[43:32] !== want.x) begin
                        $error("out_x: expected %0d, got %0d", want.x, m_tdata[43:32]);
                        mismatches++;
                    end
                    if (m_tdata[55:44] !== want.y) begin
                        $error("out_y: expected %0d, got %0d", want.y, m_tdata[55:44]);
                        mismatches++;
                    end
                    if (m_tlast !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want.frame_done) begin
                        $error("frame_done: expected %b, got %b", want.frame_done, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/pixel_art_edge_upscaler_tb.sv =====
// ----------------------------------------------------------------------------
// pixel_art_edge_upscaler_tb: stimulus and verdict for the upscaler
// Drives directed and random frames under several sizes and both scale
// modes, with random stalls on both streams; the checker compares results.
// ----------------------------------------------------------------------------
module pixel_art_edge_upscaler_tb;
    import upsc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 270;
    localparam int WIDE_ITEMS    = 60;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [55:0]            m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    int                     mismatches;
    int                     pending;
    logic                   calm_sender;
    logic [31:0]            palette [3];
    int                     idle_cycles;

    pixel_art_edge_upscaler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    upscale_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .mismatches(mismatches), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog: cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall before each word, with calm stretches
    initial begin
        int hold;
        int calm_left;
        m_tready = 1'b0;
        calm_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (calm_left == 0 && $urandom_range(0, 99) == 0) calm_left = $urandom_range(20, 80);
            hold = (calm_left > 0) ? 0 : $urandom_range(0, 7);
            if (calm_left > 0) calm_left--;
            if (hold > 0) begin
                m_tready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_pixel(input logic [31:0] p);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = p;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // drain the stream, then let items that make no words settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_frame(input int w, input int h, input logic m3);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_SCALE_MODE, CFG_DATA_W'(m3));
    endtask

    function automatic logic [31:0] pick_pixel(input int noise_pct);
        if ($urandom_range(0, 99) < noise_pct) return $urandom;
        return palette[$urandom_range(0, 2)];
    endfunction

    initial begin
        logic [31:0] lo, hi;
        int sent, w, h, n, noise;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_FRAME_WIDTH;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm_sender = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: 4x3 two-tone frame in both modes
        lo = 32'h0000_0000;
        hi = 32'hFFFF_FFFF;
        for (int mode = 0; mode < 2; mode++) begin
            set_frame(4, 3, mode[0]);
            send_pixel(lo); send_pixel(hi); send_pixel(lo); send_pixel(lo);
            send_pixel(hi); send_pixel(lo); send_pixel(hi); send_pixel(hi);
            send_pixel(lo); send_pixel(lo); send_pixel(hi); send_pixel(lo);
        end
        // single pixel frame, zero sizes treated as one
        set_frame(1, 1, 1'b1);
        send_pixel(32'hA5A5_5A5A);
        set_frame(0, 0, 1'b0);
        send_pixel(32'h5A5A_A5A5);
        send_pixel(32'h1234_5678);
        // unmapped index is ignored, frame goes on
        set_frame(2, 2, 1'b1);
        send_pixel(lo);
        write_reg(CFG_UNMAPPED, 11'h7FF);
        send_pixel(hi); send_pixel(hi); send_pixel(lo);
        // oversized registers saturate: start of a row at the widest size
        palette[0] = 32'h00FF_00FF; palette[1] = 32'hFF00_FF00; palette[2] = 32'h8000_0001;
        set_frame(2047, 1, 1'b0);
        calm_sender = 1'b1;
        for (int k = 0; k < WIDE_ITEMS; k++) send_pixel(pick_pixel(5));
        set_frame(1, 2047, 1'b1);
        for (int k = 0; k < 20; k++) send_pixel(pick_pixel(5));

        // random frames, mostly small and well formed
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame(w, h, 1'($urandom_range(0, 1)));
            for (int k = 0; k < 3; k++) palette[k] = $urandom;
            if ($urandom_range(0, 3) == 0) palette[1] = palette[0];
            noise = ($urandom_range(0, 4) == 0) ? 100 : 10;
            calm_sender = ($urandom_range(0, 3) == 0);
            // sometimes cut the frame short or run into the next one
            n = w * h;
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, w * h + w);
            for (int k = 0; k < n; k++) begin
                if (k == n / 2 && $urandom_range(0, 5) == 0) begin
                    s_tvalid = 1'b0;
                    while (pending != 0) @(negedge aclk);
                end
                send_pixel(pick_pixel(noise));
            end
            sent += n;
        end

        drain();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
